@@ hw/rtl/aes_pkg.sv @@
// aes_pkg: shared types, constants and functions for the aes-128 encrypt block
// depends on nothing; imported by every module in hw/rtl
package aes_pkg;

    localparam int NumRounds = 10;
    localparam int BlockBits = 128;
    localparam int KeyRegBits = 64;

    // configuration register indexes
    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    typedef logic [BlockBits-1:0] t_block;

    // one block moving down the round chain
    typedef struct packed {
        logic   valid;
        t_block data;
        t_block rkey;
    } t_stage;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tab [256];
        tab = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tab[a];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        unique case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // byte n of a block, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input t_block s, input int n);
        return s[BlockBits-1-8*n -: 8];
    endfunction

endpackage

@@ hw/rtl/aes_round_cell.sv @@
// aes_round_cell: one registered cipher round plus its round-key step
// depends on aes_pkg
module aes_round_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [3:0]      i_round,
    input  aes_pkg::t_stage i_stage,
    output aes_pkg::t_stage o_stage
);
    import aes_pkg::*;

    t_stage r_stage;
    t_stage n_stage;
    t_block sb;
    t_block mc;
    t_block nk;
    logic [31:0] t;
    logic [7:0] a0, a1, a2, a3, al;

    always_comb begin
        // subbytes and shiftrows
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sb[BlockBits-1-8*(4*c+r) -: 8] = sbox(get_byte(i_stage.data, 4*((c+r)%4)+r));
            end
        end
        // mixcolumns, skipped in the last round
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(sb, 4*c);
            a1 = get_byte(sb, 4*c+1);
            a2 = get_byte(sb, 4*c+2);
            a3 = get_byte(sb, 4*c+3);
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[BlockBits-1-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            mc[BlockBits-1-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            mc[BlockBits-1-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            mc[BlockBits-1-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        // next round key
        t = i_stage.rkey[31:0];
        t = {sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])}
            ^ {rcon(i_round), 24'h0};
        nk[127:96] = i_stage.rkey[127:96] ^ t;
        nk[95:64]  = i_stage.rkey[95:64] ^ nk[127:96];
        nk[63:32]  = i_stage.rkey[63:32] ^ nk[95:64];
        nk[31:0]   = i_stage.rkey[31:0] ^ nk[63:32];
        n_stage.valid = i_stage.valid;
        n_stage.rkey  = nk;
        n_stage.data  = ((i_round == 4'(NumRounds)) ? sb : mc) ^ nk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.data <= n_stage.data;
            r_stage.rkey <= n_stage.rkey;
        end
    end

    assign o_stage = r_stage;
endmodule

@@ hw/rtl/aes128_block_encrypt.sv @@
// aes128_block_encrypt: top level, key registers, initial key add and round chain
// depends on aes_pkg and aes_round_cell
//
// usage
//   s_axis: one plaintext block per transaction, tdata = {plain_low, plain_high}
//   m_axis: one ciphertext block per transaction, tdata = {cipher_low, cipher_high}
//   key: write index 0 (key_high) and 1 (key_low) through i_cfg_we while idle;
//   other indexes are ignored
// pipeline: one register for the initial key add, then one per round cell
// throughput: one block per cycle unless a stalled m_axis holds a full chain; each round cell holds one block and the
//   round key that goes with it, so the key expansion rides the chain
// stall: when m_axis_tready is low and the last stage is full, the whole
//   chain holds; bubbles still collapse, since a cell moves when the one
//   after it is empty or moving
// reset: clears all valid bits and the key registers to zero
module aes128_block_encrypt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [63:0]   i_cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // plain_high [63:0], plain_low [127:64]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata    // cipher_high [63:0], cipher_low [127:64]
);
    import aes_pkg::*;

    logic [KeyRegBits-1:0] r_key_high;
    logic [KeyRegBits-1:0] r_key_low;
    t_stage chain [NumRounds+1];
    logic   en [NumRounds+1];
    t_stage r_first;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KEY_HIGH: r_key_high <= i_cfg_wdata;
                REG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                default:      ;
            endcase
        end
    end

    // stage enables, from the output back
    always_comb begin
        en[NumRounds] = m_axis_tready || !chain[NumRounds].valid;
        for (int k = NumRounds - 1; k >= 0; k--) begin
            en[k] = en[k+1] || !chain[k].valid;
        end
    end

    // initial add round key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first.valid <= 1'b0;
        end else if (en[0]) begin
            r_first.valid <= s_axis_tvalid;
        end
        if (en[0]) begin
            r_first.rkey <= {r_key_high, r_key_low};
            r_first.data <= {s_axis_tdata[63:0], s_axis_tdata[127:64]}
                            ^ {r_key_high, r_key_low};
        end
    end
    assign chain[0] = r_first;

    // round chain
    for (genvar g = 1; g <= NumRounds; g++) begin : g_round
        aes_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[g]),
            .i_round (4'(g)),
            .i_stage (chain[g-1]),
            .o_stage (chain[g])
        );
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = chain[NumRounds].valid;
    assign m_axis_tdata  = {chain[NumRounds].data[63:0], chain[NumRounds].data[127:64]};

    // a stalled result holds its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
    // an accepted block enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> chain[0].valid)
        else $error("accepted block lost");
    // ready only drops when the output is stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("ready dropped without stall");
endmodule

@@ verif/tb_aes128_block_encrypt.sv @@
`timescale 1ns / 100ps
// tb_aes128_block_encrypt: self-checking testbench for the aes-128 encrypt block
// depends on aes_pkg (register indexes) and aes128_block_encrypt
module tb_aes128_block_encrypt;
    import aes_pkg::*;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_halves;

    localparam int Latency = 11;
    localparam int CycleLimit = 400000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic          i_cfg_index;
    logic [63:0]   i_cfg_wdata;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata;   // plain_high [63:0], plain_low [127:64]
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [127:0]  m_axis_tdata;   // cipher_high [63:0], cipher_low [127:64]

    aes128_block_encrypt dut (.*);

    // key shadow and encryption tables
    logic [63:0] key_hi_sh, key_lo_sh;
    logic [7:0]  sub_tab [256];
    t_halves     plain_q [$];
    t_halves     cipher_q [$];
    int          send_idle_pct, recv_stall_pct;
    int          fail_cnt;
    int          cycle_cnt;

    function automatic logic [7:0] gmul2(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // forward cipher over the shadow key, bytes big-endian, column-major
    function automatic t_halves encrypt_block(input t_halves p);
        logic [31:0] w [44];
        logic [7:0]  st [16];
        logic [7:0]  tmp [16];
        logic [31:0] t;
        logic [7:0]  rc;
        logic [7:0]  a0, a1, a2, a3, all;
        t_halves     res;
        w[0] = key_hi_sh[63:32]; w[1] = key_hi_sh[31:0];
        w[2] = key_lo_sh[63:32]; w[3] = key_lo_sh[31:0];
        rc = 8'h01;
        for (int i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sub_tab[t[31:24]], sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]]};
                t ^= {rc, 24'h0};
                rc = gmul2(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int i = 0; i < 8; i++) begin
            st[i]   = p.hi[63-8*i -: 8];
            st[i+8] = p.lo[63-8*i -: 8];
        end
        for (int rnd = 0; rnd <= 10; rnd++) begin
            if (rnd > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        tmp[4*c+r] = sub_tab[st[4*((c+r)%4)+r]];
                st = tmp;
                if (rnd < 10) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                        all = a0 ^ a1 ^ a2 ^ a3;
                        st[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
                        st[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
                        st[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
                        st[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    st[4*c+r] ^= w[4*rnd+c][31-8*r -: 8];
        end
        for (int i = 0; i < 8; i++) begin
            res.hi[63-8*i -: 8] = st[i];
            res.lo[63-8*i -: 8] = st[i+8];
        end
        return res;
    endfunction

    // s-box built from gf(2^8) inverse and affine map
    initial begin
        logic [7:0] inv, x, y, acc;
        for (int a = 0; a < 256; a++) begin
            inv = 8'h00;
            for (int b = 1; b < 256; b++) begin
                x = a; y = b; acc = 0;
                for (int k = 0; k < 8; k++) begin
                    if (y[0]) acc ^= x;
                    x = gmul2(x);
                    y = y >> 1;
                end
                if (acc == 8'h01) inv = b;
            end
            sub_tab[a] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                       ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // driver: one transaction per handshake from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (plain_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {plain_q[0].lo, plain_q[0].hi};
                cipher_q.push_back(encrypt_block(plain_q[0]));
                void'(plain_q.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each output transaction with the oldest expectation
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cipher_q.size() == 0) begin
                $error("unexpected ciphertext %h", m_axis_tdata);
                fail_cnt = fail_cnt + 1;
            end else begin
                if (m_axis_tdata[63:0] !== cipher_q[0].hi) begin
                    $error("cipher_high expected %h actual %h", cipher_q[0].hi,
                           m_axis_tdata[63:0]);
                    fail_cnt = fail_cnt + 1;
                end
                if (m_axis_tdata[127:64] !== cipher_q[0].lo) begin
                    $error("cipher_low expected %h actual %h", cipher_q[0].lo,
                           m_axis_tdata[127:64]);
                    fail_cnt = fail_cnt + 1;
                end
                void'(cipher_q.pop_front());
            end
        end
        if (cycle_cnt > CycleLimit) begin
            $display("tb_aes128_block_encrypt: errors");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic write_key(input logic idx, input logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_KEY_HIGH) key_hi_sh = val;
        else key_lo_sh = val;
    endtask

    task automatic drain();
        wait (plain_q.size() == 0 && cipher_q.size() == 0 && !s_axis_tvalid);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    task automatic queue_plain(input logic [63:0] h, input logic [63:0] l);
        t_halves p;
        p.hi = h;
        p.lo = l;
        plain_q.push_back(p);
    endtask

    initial begin
        logic [63:0] h, l;
        int mode;
        fail_cnt = 0;
        cycle_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        key_hi_sh = '0;
        key_lo_sh = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_KEY_HIGH;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset key of zero, then standard vector, then all-ones
        queue_plain('0, '0);
        queue_plain('1, '1);
        drain();
        write_key(REG_KEY_HIGH, 64'h0001020304050607);
        write_key(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        queue_plain(64'h0011223344556677, 64'h8899aabbccddeeff);
        queue_plain('0, '0);
        queue_plain('1, '0);
        queue_plain('0, '1);
        queue_plain(64'h8000000000000000, 64'h1);
        drain();
        write_key(REG_KEY_HIGH, '1);
        write_key(REG_KEY_LOW, '1);
        queue_plain('0, '0);
        queue_plain('1, '1);
        queue_plain(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        drain();

        // random phases with changing keys and idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            write_key(REG_KEY_HIGH, (ph == 4) ? 64'h0 : rand64());
            write_key(REG_KEY_LOW, (ph == 4) ? 64'h0 : rand64());
            for (int n = 0; n < 180; n++) begin
                mode = $urandom_range(9);
                h = rand64();
                l = rand64();
                if (mode == 0) h = '0;
                else if (mode == 1) l = '1;
                queue_plain(h, l);
            end
            drain();
        end

        if (fail_cnt == 0)
            $display("tb_aes128_block_encrypt: clean");
        else
            $display("tb_aes128_block_encrypt: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/aes_pkg.sv
hw/rtl/aes_round_cell.sv
hw/rtl/aes128_block_encrypt.sv
verif/tb_aes128_block_encrypt.sv
